// ----- hdl/lpcs_pkg.sv -----
// shared constants and types for the lint pseudo-comment scanner
`default_nettype none

package lpcs_pkg;

   // word buffer size and derived widths
   localparam int WORD_CAPACITY = 12;
   localparam int LEN_W         = $clog2(WORD_CAPACITY + 1);
   localparam int IDX_W         = $clog2(WORD_CAPACITY);

   // item kinds on the request channel
   typedef enum logic [1:0] {
      REQ_START       = 2'd0,
      REQ_CHAR        = 2'd1,
      REQ_COMMIT_STMT = 2'd2,
      REQ_COMMIT_FUNC = 2'd3
   } req_kind_type;

   // character codes of interest
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // keywords, written reversed so the first character sits in the low byte
   localparam int KW_NOTREACHED_LEN = 10;
   localparam int KW_ARGSUSED_LEN   = 8;
   localparam int KW_LINTLIB_LEN    = 11;
   localparam int KW_VARARGS_LEN    = 7;

   localparam logic [8*KW_NOTREACHED_LEN-1:0] KW_NOTREACHED = "DEHCAERTON";
   localparam logic [8*KW_ARGSUSED_LEN-1:0]   KW_ARGSUSED   = "DESUSGRA";
   localparam logic [8*KW_LINTLIB_LEN-1:0]    KW_LINTLIB    = "YRARBILTNIL";
   localparam logic [8*KW_VARARGS_LEN-1:0]    KW_VARARGS    = "SGRARAV";

   // variable-argument count when none is given
   localparam logic signed [4:0] VARARGS_NONE = -5'sd1;

   // committed flags as returned with every item
   typedef struct packed {
      logic              lint_library;
      logic              args_used;
      logic signed [4:0] varargs_count;
      logic              not_reached;
   } flags_type;

endpackage

`default_nettype wire

// ----- hdl/lint_pseudo_comment_scanner.sv -----
// top level of the lint pseudo-comment scanner
`default_nettype none

// channel  dir  tdata                               tuser
// req_     in   [7:0] char_code                     [1:0] req_type
// rsp_     out  [0] not_reached, [5:1] varargs_count,
//               [6] args_used, [7] lint_library      -
//
// every item gives exactly one result item, one item per cycle sustained while rsp_tready is high
// each item passes an input register, then the scan step into the result register
// the input register refills in the same cycle that it drains, so a stalled result
// still leaves room for one more item
// synchronous active-high reset returns the scanner to skipping spaces with all flags clear
// and the pending variable-argument count at none

module lint_pseudo_comment_scanner (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic [1:0] req_tuser,   // [1:0] req_type
   // result channel
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] not_reached, [5:1] varargs_count,
                                        // [6] args_used, [7] lint_library
);

   // scan position within the current comment
   typedef enum logic [1:0] {
      SCAN_SPACE,
      SCAN_WORD,
      SCAN_DONE
   } scan_state_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic [1:0] in_kind_ff, in_kind_in;

   // scanner state
   scan_state_type                     scan_ff, scan_in;
   logic [7:0]                         word_chars_ff [lpcs_pkg::WORD_CAPACITY];
   logic [lpcs_pkg::LEN_W-1:0]         word_length_ff, word_length_in;
   logic                               word_we;
   logic [lpcs_pkg::IDX_W-1:0]         word_idx;

   logic                               pend_not_reached_ff, pend_not_reached_in;
   logic signed [4:0]                  pend_varargs_ff, pend_varargs_in;
   logic                               pend_args_used_ff, pend_args_used_in;
   lpcs_pkg::flags_type                held_ff, held_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   lpcs_pkg::flags_type                rsp_data_ff, rsp_data_in;

   // matching
   logic [8*lpcs_pkg::WORD_CAPACITY-1:0] word_vec;
   logic                                 word_short;
   logic                                 hit_not_reached;
   logic                                 hit_args_used;
   logic                                 hit_lint_library;
   logic                                 hit_varargs_bare;
   logic                                 hit_varargs_digit;
   logic [7:0]                           digit_off;

   logic                                 advance;
   logic                                 is_blank;
   logic                                 is_delim;
   lpcs_pkg::req_kind_type               item_kind;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign item_kind = lpcs_pkg::req_kind_type'(in_kind_ff);
   assign is_blank  = (in_char_ff == lpcs_pkg::CHAR_SPACE) || (in_char_ff == lpcs_pkg::CHAR_TAB);
   assign is_delim  = is_blank || (in_char_ff == lpcs_pkg::CHAR_STAR);
   assign word_idx  = word_length_ff[lpcs_pkg::IDX_W-1:0];

   // flatten the word buffer, first character in the low byte
   always_comb begin
      for (int i = 0; i < lpcs_pkg::WORD_CAPACITY; i++) begin
         word_vec[8*i +: 8] = word_chars_ff[i];
      end
   end

   // parallel keyword compare, a full buffer never matches
   always_comb begin
      word_short = word_length_ff < lpcs_pkg::LEN_W'(lpcs_pkg::WORD_CAPACITY);
      hit_not_reached = word_short
         && (word_length_ff == lpcs_pkg::LEN_W'(lpcs_pkg::KW_NOTREACHED_LEN))
         && (word_vec[8*lpcs_pkg::KW_NOTREACHED_LEN-1:0] == lpcs_pkg::KW_NOTREACHED);
      hit_args_used = word_short
         && (word_length_ff == lpcs_pkg::LEN_W'(lpcs_pkg::KW_ARGSUSED_LEN))
         && (word_vec[8*lpcs_pkg::KW_ARGSUSED_LEN-1:0] == lpcs_pkg::KW_ARGSUSED);
      hit_lint_library = word_short
         && (word_length_ff == lpcs_pkg::LEN_W'(lpcs_pkg::KW_LINTLIB_LEN))
         && (word_vec[8*lpcs_pkg::KW_LINTLIB_LEN-1:0] == lpcs_pkg::KW_LINTLIB);
      hit_varargs_bare = word_short
         && (word_length_ff == lpcs_pkg::LEN_W'(lpcs_pkg::KW_VARARGS_LEN))
         && (word_vec[8*lpcs_pkg::KW_VARARGS_LEN-1:0] == lpcs_pkg::KW_VARARGS);
      // keyword followed by one decimal digit
      hit_varargs_digit = word_short
         && (word_length_ff == lpcs_pkg::LEN_W'(lpcs_pkg::KW_VARARGS_LEN + 1))
         && (word_vec[8*lpcs_pkg::KW_VARARGS_LEN-1:0] == lpcs_pkg::KW_VARARGS)
         && (word_chars_ff[lpcs_pkg::KW_VARARGS_LEN] >= lpcs_pkg::CHAR_ZERO)
         && (word_chars_ff[lpcs_pkg::KW_VARARGS_LEN] <= lpcs_pkg::CHAR_NINE);
      digit_off = word_chars_ff[lpcs_pkg::KW_VARARGS_LEN] - lpcs_pkg::CHAR_ZERO;
   end

   // next state for one item
   always_comb begin
      in_valid_in         = in_valid_ff;
      in_char_in          = in_char_ff;
      in_kind_in          = in_kind_ff;
      scan_in             = scan_ff;
      word_length_in      = word_length_ff;
      word_we             = 1'b0;
      pend_not_reached_in = pend_not_reached_ff;
      pend_varargs_in     = pend_varargs_ff;
      pend_args_used_in   = pend_args_used_ff;
      held_in             = held_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      rsp_data_in         = rsp_data_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         unique case (item_kind)
            lpcs_pkg::REQ_START: begin
               scan_in        = SCAN_SPACE;
               word_length_in = '0;
            end
            lpcs_pkg::REQ_CHAR: begin
               // leading blanks are skipped, a star ends the scan, anything else opens the word
               if ((scan_ff == SCAN_WORD) || (scan_ff == SCAN_SPACE && !is_blank)) begin
                  if (is_delim) begin
                     scan_in = SCAN_DONE;
                     if (hit_not_reached) begin
                        pend_not_reached_in = 1'b1;
                     end else if (hit_args_used) begin
                        pend_args_used_in = 1'b1;
                     end else if (hit_lint_library) begin
                        held_in.lint_library = 1'b1;
                     end else if (hit_varargs_bare) begin
                        pend_varargs_in = '0;
                     end else if (hit_varargs_digit) begin
                        pend_varargs_in = 5'(digit_off);
                     end
                  end else if (word_short) begin
                     scan_in        = SCAN_WORD;
                     word_we        = 1'b1;
                     word_length_in = word_length_ff + 1'b1;
                  end else begin
                     // overlong word, give up on this comment
                     scan_in = SCAN_DONE;
                  end
               end
            end
            lpcs_pkg::REQ_COMMIT_STMT: begin
               held_in.not_reached = pend_not_reached_ff;
               pend_not_reached_in = 1'b0;
            end
            lpcs_pkg::REQ_COMMIT_FUNC: begin
               held_in.varargs_count = pend_varargs_ff;
               held_in.args_used     = pend_args_used_ff;
               pend_varargs_in       = lpcs_pkg::VARARGS_NONE;
               pend_args_used_in     = 1'b0;
            end
            default: begin
            end
         endcase
         rsp_valid_in = 1'b1;
         rsp_data_in  = held_in;
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_kind_in  = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         scan_ff             <= SCAN_SPACE;
         word_length_ff      <= '0;
         pend_not_reached_ff <= 1'b0;
         pend_varargs_ff     <= lpcs_pkg::VARARGS_NONE;
         pend_args_used_ff   <= 1'b0;
         held_ff             <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         in_valid_ff         <= in_valid_in;
         scan_ff             <= scan_in;
         word_length_ff      <= word_length_in;
         pend_not_reached_ff <= pend_not_reached_in;
         pend_varargs_ff     <= pend_varargs_in;
         pend_args_used_ff   <= pend_args_used_in;
         held_ff             <= held_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      in_char_ff  <= in_char_in;
      in_kind_ff  <= in_kind_in;
      rsp_data_ff <= rsp_data_in;
      if (word_we) begin
         word_chars_ff[word_idx] <= in_char_ff;
      end
   end

endmodule

`default_nettype wire
